@@ src/utf8_code_point_set_trim_top_defines.svh @@
// Assertion macros shared by the trim block. Each use sits on a line of its own.
// The enclosing module must have clk and arst_n in scope.
`ifndef UTF8_CODE_POINT_SET_TRIM_TOP_DEFINES_SVH
`define UTF8_CODE_POINT_SET_TRIM_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define UCT_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);
`define UCT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define UCT_ASSERT(lbl, expr, msg)
`define UCT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ src/uctrim_pkg.sv @@
`timescale 1ns / 1ps
package uctrim_pkg;

	localparam int TRIM_ENTRIES_DEF = 6;
	localparam int OFFSET_BITS_DEF  = 16;
	localparam int QUEUE_DEPTH      = 2;

	localparam int BYTE_W     = 8;
	localparam int CP_W       = 32;
	localparam int OUT_W      = 16;
	localparam int MODE_W     = 2;
	localparam int COUNT_W    = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_MODE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CP0   = 3'd2;

	localparam logic [MODE_W-1:0] MODE_RESET = 2'b11;
	localparam int MODE_LEFT_BIT  = 0;
	localparam int MODE_RIGHT_BIT = 1;

	// Lead and continuation byte patterns.
	localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'b1111_1000;
	localparam logic [BYTE_W-1:0] LEAD4_VAL  = 8'b1111_0000;
	localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'b1111_0000;
	localparam logic [BYTE_W-1:0] LEAD3_VAL  = 8'b1110_0000;
	localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'b1110_0000;
	localparam logic [BYTE_W-1:0] LEAD2_VAL  = 8'b1100_0000;
	localparam logic [BYTE_W-1:0] CONT_MASK  = 8'b1100_0000;
	localparam logic [BYTE_W-1:0] CONT_VAL   = 8'b1000_0000;

	typedef logic [2:0] ulen_t;

	// What one accepted byte does to the trim bookkeeping.
	typedef struct packed {
		logic nt_early;   // truncated unit closes as non-trim at this byte's offset
		logic unit_close; // a unit closes at the offset after this byte
		logic unit_trim;  // that unit matched a trim entry
		logic final_nt;   // unit left open at the last byte closes as non-trim
		logic last;
		logic ovf;
	} uctrim_ev_t;

	function automatic ulen_t lead_len(input logic [BYTE_W-1:0] b);
		ulen_t len;
		if ((b & LEAD4_MASK) == LEAD4_VAL) len = 3'd4;
		else if ((b & LEAD3_MASK) == LEAD3_VAL) len = 3'd3;
		else if ((b & LEAD2_MASK) == LEAD2_VAL) len = 3'd2;
		else len = 3'd1;
		return len;
	endfunction

	function automatic logic is_cont(input logic [BYTE_W-1:0] b);
		return (b & CONT_MASK) == CONT_VAL;
	endfunction

	function automatic logic [CP_W-1:0] top_mask(input ulen_t len);
		logic [CP_W-1:0] m;
		case (len)
			3'd0:    m = 32'h0000_0000;
			3'd1:    m = 32'hFF00_0000;
			3'd2:    m = 32'hFFFF_0000;
			3'd3:    m = 32'hFFFF_FF00;
			default: m = 32'hFFFF_FFFF;
		endcase
		return m;
	endfunction

endpackage

@@ src/uctrim_front.sv @@
`timescale 1ns / 1ps
`include "utf8_code_point_set_trim_top_defines.svh"
module uctrim_front #(
	parameter int TRIM_ENTRIES = uctrim_pkg::TRIM_ENTRIES_DEF,
	parameter int OFFSET_BITS  = uctrim_pkg::OFFSET_BITS_DEF
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        in_valid,
	output logic                                        in_stall,
	input  logic [uctrim_pkg::BYTE_W-1:0]               in_byte,
	input  logic                                        last_byte,
	input  logic [uctrim_pkg::COUNT_W-1:0]              trim_count,
	input  logic [TRIM_ENTRIES-1:0][uctrim_pkg::CP_W-1:0] trim_cp,
	input  logic                                        q_full,
	output logic                                        q_push,
	output uctrim_pkg::uctrim_ev_t                      ev,
	output logic [OFFSET_BITS-1:0]                      here,
	output logic [OFFSET_BITS-1:0]                      next_pos
);
	import uctrim_pkg::*;

	logic [OFFSET_BITS-1:0] pos_q;
	logic [CP_W-1:0]        partial_q;
	logic [1:0]             need_q;
	logic                   ovf_q;

	logic                   at_max;
	logic                   ovf_new;
	logic                   cont;
	ulen_t                  part_len;
	ulen_t                  cmp_len;
	logic [1:0]             idx;
	logic [1:0]             slot;
	logic [CP_W-1:0]        partial_new;
	logic [1:0]             need_new;
	logic                   check;
	logic                   hit;

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;
	assign here     = pos_q;

	always_comb begin
		at_max   = &pos_q;
		next_pos = at_max ? pos_q : pos_q + 1'b1;
		ovf_new  = ovf_q | at_max;
		cont     = is_cont(in_byte);
		part_len = lead_len(partial_q[CP_W-1 -: BYTE_W]);
		idx      = 2'(part_len - {1'b0, need_q});
		slot     = 2'd3 - idx;

		partial_new = partial_q;
		need_new    = need_q;
		cmp_len     = part_len;
		check       = 1'b0;
		ev          = '0;

		if (need_q != 2'd0 && cont) begin
			partial_new = partial_q | ({24'b0, in_byte} << {slot, 3'b000});
			need_new    = need_q - 2'd1;
			if (need_new == 2'd0) begin
				ev.unit_close = 1'b1;
				check         = 1'b1;
			end
		end else begin
			ev.nt_early = (need_q != 2'd0);
			need_new    = 2'd0;
			if (cont) begin
				// A stray continuation byte is a one-byte unit that never matches.
				ev.unit_close = 1'b1;
			end else begin
				partial_new = {in_byte, 24'b0};
				cmp_len     = lead_len(in_byte);
				if (cmp_len == 3'd1) begin
					ev.unit_close = 1'b1;
					check         = 1'b1;
				end else begin
					need_new = 2'(cmp_len - 3'd1);
				end
			end
		end

		hit = 1'b0;
		for (int k = 0; k < TRIM_ENTRIES; k++) begin
			if (COUNT_W'(k) < trim_count &&
			    lead_len(trim_cp[k][CP_W-1 -: BYTE_W]) == cmp_len &&
			    (trim_cp[k] & top_mask(cmp_len)) == partial_new)
				hit = 1'b1;
		end

		ev.unit_trim = check && hit;
		ev.final_nt  = last_byte && (need_new != 2'd0);
		ev.last      = last_byte;
		ev.ovf       = ovf_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			partial_q <= '0;
			need_q    <= 2'd0;
			ovf_q     <= 1'b0;
		end else if (q_push) begin
			if (last_byte) begin
				pos_q     <= '0;
				partial_q <= '0;
				need_q    <= 2'd0;
				ovf_q     <= 1'b0;
			end else begin
				pos_q     <= next_pos;
				partial_q <= partial_new;
				need_q    <= need_new;
				ovf_q     <= ovf_new;
			end
		end
	end

	// An open unit always holds a multi-byte lead in its top byte.
	`UCT_ASSERT(a_open_unit_lead, need_q == 2'd0 || partial_q[CP_W-1 -: 2] == 2'b11, "open unit without a multi-byte lead")
	// Overflow is only flagged once the offset has saturated.
	`UCT_ASSERT(a_ovf_saturated, !ovf_q || (&pos_q), "overflow flag set below the saturated offset")

endmodule

@@ src/uctrim_fifo.sv @@
`timescale 1ns / 1ps
`include "utf8_code_point_set_trim_top_defines.svh"
module uctrim_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = uctrim_pkg::QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	output logic         full,
	input  logic         pop,
	output logic         valid,
	output logic [W-1:0] dout
);
	import uctrim_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [W-1:0]     mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign valid = (cnt_q != '0);
	assign dout  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)  rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	`UCT_ASSERT(a_pop_nonempty, !pop || cnt_q != '0, "queue popped while empty")
	`UCT_ASSERT(a_push_room, !push || !full || pop, "queue pushed while full")

endmodule

@@ src/uctrim_back.sv @@
`timescale 1ns / 1ps
`include "utf8_code_point_set_trim_top_defines.svh"
module uctrim_back #(
	parameter int OFFSET_BITS = uctrim_pkg::OFFSET_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	input  uctrim_pkg::uctrim_ev_t        q_ev,
	input  logic [OFFSET_BITS-1:0]        q_here,
	input  logic [OFFSET_BITS-1:0]        q_next,
	output logic                          q_pop,
	input  logic [uctrim_pkg::MODE_W-1:0] trim_mode,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [uctrim_pkg::OUT_W-1:0]  keep_start,
	output logic [uctrim_pkg::OUT_W-1:0]  keep_length,
	output logic                          too_long
);
	import uctrim_pkg::*;

	logic                   in_lead_q;
	logic [OFFSET_BITS-1:0] le_q;
	logic [OFFSET_BITS-1:0] lke_q;
	logic                   out_valid_q;
	logic [OUT_W-1:0]       keep_start_q;
	logic [OUT_W-1:0]       keep_length_q;
	logic                   too_long_q;

	logic                   lead_d;
	logic [OFFSET_BITS-1:0] le_d;
	logic [OFFSET_BITS-1:0] lke_d;
	logic [OFFSET_BITS-1:0] start_pos;
	logic [OFFSET_BITS-1:0] end_pos;
	logic [OFFSET_BITS-1:0] len_pos;
	logic [OFFSET_BITS+OUT_W-1:0] start_ext;
	logic [OFFSET_BITS+OUT_W-1:0] len_ext;

	// A string's final beat waits here until the result register is free.
	assign q_pop = q_valid && (!q_ev.last || !out_valid_q || !out_stall);

	always_comb begin
		lead_d = in_lead_q;
		le_d   = le_q;
		lke_d  = lke_q;
		// Closes are applied in stream order: truncated unit, then the unit
		// this byte completes, then a unit left open at the end of the string.
		if (q_ev.nt_early) begin
			lead_d = 1'b0;
			lke_d  = q_here;
		end
		if (q_ev.unit_close) begin
			if (q_ev.unit_trim) begin
				if (lead_d) le_d = q_next;
			end else begin
				lead_d = 1'b0;
				lke_d  = q_next;
			end
		end
		if (q_ev.final_nt) begin
			lead_d = 1'b0;
			lke_d  = q_next;
		end

		start_pos = trim_mode[MODE_LEFT_BIT]  ? le_d  : '0;
		end_pos   = trim_mode[MODE_RIGHT_BIT] ? lke_d : q_next;
		len_pos   = (end_pos > start_pos) ? end_pos - start_pos : '0;
		start_ext = {{OUT_W{1'b0}}, start_pos};
		len_ext   = {{OUT_W{1'b0}}, len_pos};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_lead_q <= 1'b1;
			le_q      <= '0;
			lke_q     <= '0;
		end else if (q_pop) begin
			if (q_ev.last) begin
				in_lead_q <= 1'b1;
				le_q      <= '0;
				lke_q     <= '0;
			end else begin
				in_lead_q <= lead_d;
				le_q      <= le_d;
				lke_q     <= lke_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_pop && q_ev.last) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_ev.last) begin
			keep_start_q  <= start_ext[OUT_W-1:0];
			keep_length_q <= len_ext[OUT_W-1:0];
			too_long_q    <= q_ev.ovf;
		end
	end

	assign out_valid   = out_valid_q;
	assign keep_start  = keep_start_q;
	assign keep_length = keep_length_q;
	assign too_long    = too_long_q;

	`UCT_ASSERT_NEXT(a_clear_after_last, q_pop && q_ev.last, in_lead_q && le_q == '0 && lke_q == '0, "stream state not cleared after final beat")

endmodule

@@ src/utf8_code_point_set_trim_top.sv @@
// The final byte's event passes through the queue before the result register loads.
// Throughput: one byte per cycle unless stalled; the two-entry queue between the
// parser and trim tracker and the result register let each side stall on its own.
// Reset (arst_n low, asynchronous) clears the stream state, empties the queue and
// sets trim_mode to 3, trim_count to 0 and all trim entries to 0.
`timescale 1ns / 1ps
module utf8_code_point_set_trim_top #(
	parameter int TRIM_ENTRIES = uctrim_pkg::TRIM_ENTRIES_DEF,
	parameter int OFFSET_BITS  = uctrim_pkg::OFFSET_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [uctrim_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [uctrim_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [uctrim_pkg::BYTE_W-1:0]     in_byte,
	input  logic                              last_byte,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [uctrim_pkg::OUT_W-1:0]      keep_start,
	output logic [uctrim_pkg::OUT_W-1:0]      keep_length,
	output logic                              too_long
);
	import uctrim_pkg::*;

	localparam int EV_W = $bits(uctrim_ev_t);
	localparam int Q_W  = EV_W + 2 * OFFSET_BITS;

	logic [MODE_W-1:0]                 mode_q;
	logic [COUNT_W-1:0]                count_q;
	logic [TRIM_ENTRIES-1:0][CP_W-1:0] cp_q;

	logic                   q_push;
	logic                   q_full;
	logic                   q_pop;
	logic                   q_valid;
	uctrim_ev_t             f_ev;
	logic [OFFSET_BITS-1:0] f_here;
	logic [OFFSET_BITS-1:0] f_next;
	logic [Q_W-1:0]         q_din;
	logic [Q_W-1:0]         q_dout;
	uctrim_ev_t             b_ev;
	logic [OFFSET_BITS-1:0] b_here;
	logic [OFFSET_BITS-1:0] b_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_RESET;
			count_q <= '0;
			cp_q    <= '0;
		end else if (cfg_write) begin
			if (cfg_index == REG_MODE) mode_q <= cfg_data[MODE_W-1:0];
			if (cfg_index == REG_COUNT) count_q <= cfg_data[COUNT_W-1:0];
			for (int k = 0; k < TRIM_ENTRIES; k++) begin
				if (cfg_index == CFG_IDX_W'(int'(REG_CP0) + k)) cp_q[k] <= cfg_data[CP_W-1:0];
			end
		end
	end

	uctrim_front #(
		.TRIM_ENTRIES(TRIM_ENTRIES),
		.OFFSET_BITS (OFFSET_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_byte   (in_byte),
		.last_byte (last_byte),
		.trim_count(count_q),
		.trim_cp   (cp_q),
		.q_full    (q_full),
		.q_push    (q_push),
		.ev        (f_ev),
		.here      (f_here),
		.next_pos  (f_next)
	);

	assign q_din = {f_ev, f_here, f_next};

	uctrim_fifo #(
		.W    (Q_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.din   (q_din),
		.full  (q_full),
		.pop   (q_pop),
		.valid (q_valid),
		.dout  (q_dout)
	);

	assign {b_ev, b_here, b_next} = q_dout;

	uctrim_back #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_ev       (b_ev),
		.q_here     (b_here),
		.q_next     (b_next),
		.q_pop      (q_pop),
		.trim_mode  (mode_q),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.keep_start (keep_start),
		.keep_length(keep_length),
		.too_long   (too_long)
	);

endmodule
